FILE: design/ptc_pkg.sv
// Shared types, constants and saturation helpers for the pressure/temperature
// compensation pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W = 24;
    localparam int SCALE_W  = 21;
    localparam int QUO_W    = 33;   // quotient bits computed by the divider
    localparam int FRAC     = 24;

    // Pipeline depths
    localparam int DIV_LAT  = QUO_W + 2;
    localparam int POLY_LAT = 7;

    // Register indexes
    localparam logic [2:0] REG_TEMP_COEF   = 3'd0;
    localparam logic [2:0] REG_PRESS_COEFA = 3'd1;
    localparam logic [2:0] REG_PRESS_COEFB = 3'd2;
    localparam logic [2:0] REG_TEMP_SCALE  = 3'd3;
    localparam logic [2:0] REG_PRESS_SCALE = 3'd4;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 21'd524288;

    typedef logic signed [31:0] smp_t;
    typedef logic signed [55:0] im_t;
    typedef logic signed [65:0] wide_t;

    localparam wide_t IM_HI = 66'sh007FFFFFFFFFFFFF;
    localparam wide_t IM_LO = -IM_HI - 66'sd1;
    localparam wide_t S_HI  = 66'sh7FFFFFFF;
    localparam wide_t S_LO  = -S_HI - 66'sd1;

    // clamp to the 56-bit intermediate range
    function automatic im_t clamp_im(input wide_t x);
        im_t r;
        if (x > IM_HI)
            r = IM_HI[55:0];
        else if (x < IM_LO)
            r = IM_LO[55:0];
        else
            r = x[55:0];
        return r;
    endfunction

    // saturate to int32
    function automatic smp_t sat32(input wide_t x);
        smp_t r;
        if (x > S_HI)
            r = S_HI[31:0];
        else if (x < S_LO)
            r = S_LO[31:0];
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/pressure_temp_compensation_core.sv
// Top level: configuration registers, valid pipeline, two sample dividers and
// the polynomial datapath. Depends on ptc_pkg, ptc_div, ptc_poly.
// Depth: 42 register stages (35 divider + 7 polynomial); a result leaves from the last one.
// Throughput: one item per cycle; the last pipeline register is the output register
// and the whole pipeline holds while a result waits and m_axis_tready is low.
// Reset: rst_n asynchronous active low; clears valid bits, coefficient words to 0,
// scale registers to 524288.
`timescale 1ns / 1ps
`default_nettype none

module pressure_temp_compensation_core
    import ptc_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // [23:0] temp_raw, [47:24] press_raw
    // result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // [31:0] temperature_q16, [63:32] pressure_q8
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int TOTAL = DIV_LAT + POLY_LAT;

    logic [23:0]        temp_coef_reg;
    logic [55:0]        press_coef_a_reg;
    logic [63:0]        press_coef_b_reg;
    logic [SCALE_W-1:0] temp_scale_reg;
    logic [SCALE_W-1:0] press_scale_reg;

    logic [TOTAL-1:0] vld_reg;
    logic [TOTAL-1:0] vld_next;
    logic             adv;

    smp_t t_s, p_s, tq, pq;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coef_reg    <= '0;
            press_coef_a_reg <= '0;
            press_coef_b_reg <= '0;
            temp_scale_reg   <= SCALE_RESET;
            press_scale_reg  <= SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TEMP_COEF:   temp_coef_reg    <= cfg_data[23:0];
                REG_PRESS_COEFA: press_coef_a_reg <= cfg_data[55:0];
                REG_PRESS_COEFB: press_coef_b_reg <= cfg_data;
                REG_TEMP_SCALE:  temp_scale_reg   <= cfg_data[SCALE_W-1:0];
                REG_PRESS_SCALE: press_scale_reg  <= cfg_data[SCALE_W-1:0];
                default:         ;
            endcase
        end
    end

    // pipeline advance: moves whenever the output register is empty or taken
    assign adv           = !vld_reg[TOTAL-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign vld_next      = {vld_reg[TOTAL-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // sample scaling
    ptc_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div_t
    (
        .clk   (clk),
        .en    (adv),
        .raw   (s_axis_tdata[23:0]),
        .scale (temp_scale_reg),
        .quo   (t_s)
    );

    ptc_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div_p
    (
        .clk   (clk),
        .en    (adv),
        .raw   (s_axis_tdata[47:24]),
        .scale (press_scale_reg),
        .quo   (p_s)
    );

    // polynomial
    ptc_poly u_poly
    (
        .clk          (clk),
        .en           (adv),
        .t_in         (t_s),
        .p_in         (p_s),
        .temp_coef    (temp_coef_reg),
        .press_coef_a (press_coef_a_reg),
        .press_coef_b (press_coef_b_reg),
        .tq           (tq),
        .pq           (pq)
    );

    assign m_axis_tvalid = vld_reg[TOTAL-1];
    assign m_axis_tdata  = {pq, tq};

    // a waiting result blocks new items
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    // valid bits shift one place per advance
    assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> (vld_reg[TOTAL-1] == $past(vld_reg[TOTAL-2])))
        else $error("valid bit lost or duplicated in pipeline");

    // a held pipeline keeps every valid bit
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid pipeline changed during stall");

endmodule

`default_nettype wire

FILE: design/ptc_div.sv
// Pipelined restoring divider: floor(sext(raw) * 2^24 / scale), clamped to Q8.24.
// One quotient bit per stage. Depends on ptc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptc_div
    import ptc_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [SAMPLE_W-1:0] raw,
    input  wire logic [SCALE_W-1:0]  scale,
    output smp_t                     quo
);

    localparam int SHIFT = SAMPLE_W - SAMPLE_BITS;

    logic [SCALE_W-1:0]  dvs;
    logic [SAMPLE_W-1:0] raw_sh;
    logic signed [SAMPLE_W-1:0] sx;
    logic                in_neg;
    logic [SAMPLE_W-1:0] in_mag;
    logic                in_ovf;

    logic [SCALE_W-1:0]  rem_reg [0:QUO_W];
    logic [QUO_W-1:0]    q_reg   [0:QUO_W];
    logic [SAMPLE_W-1:0] mag_reg [0:QUO_W];
    logic                neg_reg [0:QUO_W];
    logic                ovf_reg [0:QUO_W];

    logic [SCALE_W-1:0]  rem_next [1:QUO_W];
    logic [QUO_W-1:0]    q_next   [1:QUO_W];

    logic [QUO_W:0]      ceil_q;
    smp_t                quo_reg;
    smp_t                quo_next;

    // a zero scale acts as one
    assign dvs = (scale == '0) ? SCALE_W'(1) : scale;

    // sign-extend from SAMPLE_BITS, take magnitude, flag a quotient of 2^33 or more
    always_comb
    begin
        raw_sh = raw << SHIFT;
        sx     = $signed(raw_sh) >>> SHIFT;
        in_neg = sx[SAMPLE_W-1];
        in_mag = in_neg ? SAMPLE_W'(-(SAMPLE_W+1)'(sx)) : SAMPLE_W'(sx);
        in_ovf = {6'd0, in_mag} >= {dvs, 9'd0};
    end

    // one quotient bit per stage; bit i of the numerator {mag, 24'b0}
    always_comb
    begin
        logic [QUO_W-1:0]   num_lo;
        logic [SCALE_W:0]   trial;
        logic               ge;
        int                 i;
        for (int j = 1; j <= QUO_W; j++)
        begin
            i      = QUO_W - j;
            num_lo = {mag_reg[j-1][8:0], 24'd0};
            trial  = {rem_reg[j-1], num_lo[i]};
            ge     = trial >= {1'b0, dvs};
            rem_next[j] = SCALE_W'(ge ? trial - {1'b0, dvs} : trial);
            q_next[j]    = q_reg[j-1];
            q_next[j][i] = ge;
        end
    end

    // floor correction and clamp
    always_comb
    begin
        ceil_q = {1'b0, q_reg[QUO_W]} + (QUO_W+1)'(rem_reg[QUO_W] != '0);
        if (neg_reg[QUO_W])
        begin
            if (ovf_reg[QUO_W] || ceil_q > (QUO_W+1)'(34'h080000000))
                quo_next = S_LO[31:0];
            else
                quo_next = 32'(-ceil_q);
        end
        else
        begin
            if (ovf_reg[QUO_W] || q_reg[QUO_W] > QUO_W'(33'h07FFFFFFF))
                quo_next = S_HI[31:0];
            else
                quo_next = q_reg[QUO_W][31:0];
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= SCALE_W'(in_mag >> 9);
            q_reg[0]   <= '0;
            mag_reg[0] <= in_mag;
            neg_reg[0] <= in_neg;
            ovf_reg[0] <= in_ovf;
            for (int j = 1; j <= QUO_W; j++)
            begin
                rem_reg[j] <= rem_next[j];
                q_reg[j]   <= q_next[j];
                mag_reg[j] <= mag_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

FILE: design/ptc_poly.sv
// Seven-stage polynomial datapath: temperature line and Horner pressure polynomial
// with 56-bit clamped intermediates. Depends on ptc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptc_poly
    import ptc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire smp_t        t_in,
    input  wire smp_t        p_in,
    input  wire logic [23:0] temp_coef,
    input  wire logic [55:0] press_coef_a,
    input  wire logic [63:0] press_coef_b,
    output smp_t             tq,
    output smp_t             pq
);

    logic signed [11:0] c0, c1;
    logic signed [19:0] c00, c10;
    logic signed [15:0] c01, c11, c20, c21, c30;

    assign c0  = $signed(temp_coef[23:12]);
    assign c1  = $signed(temp_coef[11:0]);
    assign c00 = $signed(press_coef_a[55:36]);
    assign c10 = $signed(press_coef_a[35:16]);
    assign c01 = $signed(press_coef_a[15:0]);
    assign c11 = $signed(press_coef_b[63:48]);
    assign c20 = $signed(press_coef_b[47:32]);
    assign c21 = $signed(press_coef_b[31:16]);
    assign c30 = $signed(press_coef_b[15:0]);

    // stage 1: coefficient products
    smp_t t1_reg, p1_reg;
    logic signed [47:0] c30p_reg, c21p_reg, g1_reg;
    logic signed [43:0] c1t_reg;

    // stage 2: a, d, temperature
    smp_t t2_reg, p2_reg, tq2_reg;
    logic signed [47:0] g2_reg;
    im_t a_reg, d_reg;

    // stage 3: split products for p*a and t*d
    smp_t p3_reg, tq3_reg;
    logic signed [47:0] g3_reg;
    logic signed [63:0] pah_reg, tdh_reg;
    logic signed [56:0] pal_reg, tdl_reg;

    // stage 4: b, e
    smp_t p4_reg, tq4_reg;
    logic signed [47:0] g4_reg;
    im_t b_reg, e_reg;

    // stage 5: split products for p*b and p*e
    smp_t tq5_reg;
    logic signed [47:0] g5_reg;
    logic signed [63:0] pbh_reg, peh_reg;
    logic signed [56:0] pbl_reg, pel_reg;

    // stage 6: c, f
    smp_t tq6_reg;
    logic signed [47:0] g6_reg;
    im_t c_reg, f_reg;

    // stage 7: output
    smp_t tq_reg, pq_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            t1_reg   <= t_in;
            p1_reg   <= p_in;
            c30p_reg <= c30 * p_in;
            c21p_reg <= c21 * p_in;
            g1_reg   <= c01 * t_in;
            c1t_reg  <= c1 * t_in;

            // stage 2
            t2_reg  <= t1_reg;
            p2_reg  <= p1_reg;
            g2_reg  <= g1_reg;
            a_reg   <= clamp_im((wide_t'(c20) <<< FRAC) + wide_t'(c30p_reg));
            d_reg   <= clamp_im((wide_t'(c11) <<< FRAC) + wide_t'(c21p_reg));
            tq2_reg <= sat32(((wide_t'(c0) <<< (FRAC - 1)) + wide_t'(c1t_reg)) >>> 8);

            // stage 3
            p3_reg  <= p2_reg;
            tq3_reg <= tq2_reg;
            g3_reg  <= g2_reg;
            pah_reg <= p2_reg * $signed(a_reg[55:24]);
            pal_reg <= p2_reg * $signed({1'b0, a_reg[23:0]});
            tdh_reg <= t2_reg * $signed(d_reg[55:24]);
            tdl_reg <= t2_reg * $signed({1'b0, d_reg[23:0]});

            // stage 4
            p4_reg  <= p3_reg;
            tq4_reg <= tq3_reg;
            g4_reg  <= g3_reg;
            b_reg   <= clamp_im((wide_t'(c10) <<< FRAC)
                       + wide_t'(clamp_im(wide_t'(pah_reg) + wide_t'(pal_reg >>> FRAC))));
            e_reg   <= clamp_im(wide_t'(tdh_reg) + wide_t'(tdl_reg >>> FRAC));

            // stage 5
            tq5_reg <= tq4_reg;
            g5_reg  <= g4_reg;
            pbh_reg <= p4_reg * $signed(b_reg[55:24]);
            pbl_reg <= p4_reg * $signed({1'b0, b_reg[23:0]});
            peh_reg <= p4_reg * $signed(e_reg[55:24]);
            pel_reg <= p4_reg * $signed({1'b0, e_reg[23:0]});

            // stage 6
            tq6_reg <= tq5_reg;
            g6_reg  <= g5_reg;
            c_reg   <= clamp_im((wide_t'(c00) <<< FRAC)
                       + wide_t'(clamp_im(wide_t'(pbh_reg) + wide_t'(pbl_reg >>> FRAC))));
            f_reg   <= clamp_im(wide_t'(peh_reg) + wide_t'(pel_reg >>> FRAC));

            // stage 7
            tq_reg <= tq6_reg;
            pq_reg <= sat32(wide_t'(clamp_im(wide_t'(c_reg) + wide_t'(g6_reg)
                      + wide_t'(f_reg))) >>> 16);
        end
    end

    assign tq = tq_reg;
    assign pq = pq_reg;

endmodule

`default_nettype wire
